// File: rtl/core/multi_channel_heartbeat_watchdog_unit_defines.svh
// Assertion macros shared by the watchdog checker.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef MULTI_CHANNEL_HEARTBEAT_WATCHDOG_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_HEARTBEAT_WATCHDOG_UNIT_DEFINES_SVH

// same-cycle implication
`define MCHW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("watchdog check failed");

// next-cycle implication
`define MCHW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("watchdog check failed");

`endif

// File: rtl/core/mchw_pkg.sv
// Shared types, constants and lookup functions of the heartbeat watchdog.
// No dependencies.
`default_nettype none

package mchw_pkg;

	localparam int NUM_MODULES = 8;
	localparam int MOD_W       = 3;
	localparam int TS_W        = 32;
	localparam int LOSS_W      = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int TOTAL_W     = 4;

	localparam logic [MOD_W-1:0]  LAST_MOD  = MOD_W'(NUM_MODULES - 1);
	localparam logic [LOSS_W-1:0] LOSS_MAX  = '1;

	localparam logic [CFG_W-1:0] TIMEOUTS_LOW_RST  = 64'h02EE_1D4C_012C_05DC;
	localparam logic [CFG_W-1:0] TIMEOUTS_HIGH_RST = 64'h0000_0096_02EE_03E8;
	localparam logic [CFG_W-1:0] TOLERANCES_RST    = 64'h0303_0303_0302_0303;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUTS_LOW  = 2'd0,
		REG_TIMEOUTS_HIGH = 2'd1,
		REG_TOLERANCES    = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_HEARTBEAT = 2'd0,
		ACT_EVALUATE  = 2'd1,
		ACT_RESET_ONE = 2'd2,
		ACT_RESET_ALL = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	typedef struct packed {
		action_t          action;
		logic [MOD_W-1:0] module_index;
		logic [TS_W-1:0]  now_ms;
	} cmd_t;

	typedef struct packed {
		logic [MOD_W-1:0]   report_module;
		logic               hb_good;
		logic [LOSS_W-1:0]  losses;
		logic               last_of_run;
		logic               crit_any;
		logic [TOTAL_W-1:0] critical_total;
	} rpt_t;

	typedef struct packed {
		logic [CFG_W-1:0] timeouts_low;
		logic [CFG_W-1:0] timeouts_high;
		logic [CFG_W-1:0] tolerances;
	} cfg_t;

	typedef struct packed {
		logic [TS_W-1:0]   last_seen_ms;
		logic [LOSS_W-1:0] loss_counter;
	} ram_word_t;

	typedef struct packed {
		logic             we;
		logic [MOD_W-1:0] waddr;
		ram_word_t        wdata;
		logic             re;
		logic [MOD_W-1:0] raddr;
	} ram_req_t;

	function automatic logic [15:0] timeout_of(input cfg_t cfg, input logic [MOD_W-1:0] m);
		logic [CFG_W-1:0] word;
		word = m[2] ? cfg.timeouts_high : cfg.timeouts_low;
		return word[{m[1:0], 4'b0000} +: 16];
	endfunction

	function automatic logic [LOSS_W-1:0] tolerance_of(input cfg_t cfg,
			input logic [MOD_W-1:0] m);
		return cfg.tolerances[{m, 3'b000} +: LOSS_W];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/mchw_cfg.sv
// Configuration register file of the watchdog: timeouts and tolerances.
// Depends on mchw_pkg.
`default_nettype none

module mchw_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mchw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mchw_pkg::CFG_W-1:0]      cfg_data,
	output mchw_pkg::cfg_t                       cfg
);
	import mchw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeouts_low  <= TIMEOUTS_LOW_RST;
			cfg_q.timeouts_high <= TIMEOUTS_HIGH_RST;
			cfg_q.tolerances    <= TOLERANCES_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TIMEOUTS_LOW:  cfg_q.timeouts_low  <= cfg_data;
				REG_TIMEOUTS_HIGH: cfg_q.timeouts_high <= cfg_data;
				REG_TOLERANCES:    cfg_q.tolerances    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/mchw_ram.sv
// Per-module state memory: last timestamp and loss count, one write and one
// registered read port. Depends on mchw_pkg.
`default_nettype none

module mchw_ram (
	input  wire logic               clk,
	input  wire mchw_pkg::ram_req_t req,
	output mchw_pkg::ram_word_t     rdata
);
	import mchw_pkg::*;

	ram_word_t mem [NUM_MODULES];
	ram_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/mchw_ctrl.sv
// Command sequencer and evaluation pipeline: heard flags, memory read,
// timeout check, write-back and result register. Depends on mchw_pkg.
`default_nettype none

module mchw_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire mchw_pkg::cmd_t      cmd,
	output logic                     rpt_valid,
	input  wire logic                rpt_stall,
	output mchw_pkg::rpt_t           rpt,
	input  wire mchw_pkg::cfg_t      cfg,
	output mchw_pkg::ram_req_t       ram_req,
	input  wire mchw_pkg::ram_word_t ram_rdata
);
	import mchw_pkg::*;

	state_t                 state_q, state_d;
	logic [NUM_MODULES-1:0] heard_q;
	logic [MOD_W-1:0]       rd_idx_q;
	logic [TS_W-1:0]        now_q;
	logic [TOTAL_W-1:0]     crit_q;
	logic                   s1_v_q;
	logic [MOD_W-1:0]       idx_s1;
	logic                   rpt_valid_q;
	rpt_t                   rpt_q;

	logic               cmd_acc, in_range, adv, can_issue, heard_s1, lost, crit_now;
	logic [TS_W-1:0]    elapsed;
	logic [LOSS_W-1:0]  new_loss;
	logic [TOTAL_W-1:0] crit_next;

	assign cmd_stall = (state_q != ST_IDLE) || s1_v_q;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign in_range  = ({1'b0, cmd.module_index} < TOTAL_W'(NUM_MODULES));
	assign adv       = s1_v_q && (!rpt_valid_q || !rpt_stall);

	always_comb begin
		state_d   = state_q;
		can_issue = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && cmd.action == ACT_EVALUATE)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				can_issue = !s1_v_q || adv;
				if (can_issue && rd_idx_q == LAST_MOD)
					state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// evaluation of the module whose state arrives from memory
	assign heard_s1  = heard_q[idx_s1];
	assign elapsed   = now_q - ram_rdata.last_seen_ms;
	assign lost      = heard_s1 && (elapsed > TS_W'(timeout_of(cfg, idx_s1)));
	assign new_loss  = !lost ? '0 :
		(ram_rdata.loss_counter == LOSS_MAX) ? LOSS_MAX : ram_rdata.loss_counter + 8'd1;
	assign crit_now  = heard_s1 && (new_loss > tolerance_of(cfg, idx_s1));
	assign crit_next = crit_q + TOTAL_W'(crit_now);

	always_comb begin
		ram_req       = '0;
		ram_req.re    = can_issue;
		ram_req.raddr = rd_idx_q;
		if (cmd_acc && cmd.action == ACT_HEARTBEAT && in_range) begin
			ram_req.we                 = 1'b1;
			ram_req.waddr              = cmd.module_index;
			ram_req.wdata.last_seen_ms = cmd.now_ms;
			ram_req.wdata.loss_counter = '0;
		end else if (adv && heard_s1) begin
			ram_req.we                 = 1'b1;
			ram_req.waddr              = idx_s1;
			ram_req.wdata.last_seen_ms = ram_rdata.last_seen_ms;
			ram_req.wdata.loss_counter = new_loss;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heard_q     <= '0;
			rd_idx_q    <= '0;
			crit_q      <= '0;
			s1_v_q      <= 1'b0;
			rpt_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				unique case (cmd.action)
					ACT_HEARTBEAT: if (in_range) heard_q[cmd.module_index] <= 1'b1;
					ACT_EVALUATE: begin
						rd_idx_q <= '0;
						crit_q   <= '0;
					end
					ACT_RESET_ONE: if (in_range) heard_q[cmd.module_index] <= 1'b0;
					ACT_RESET_ALL: heard_q <= '0;
				endcase
			end
			if (can_issue)
				rd_idx_q <= rd_idx_q + 3'd1;
			if (adv)
				crit_q <= crit_next;
			if (can_issue)
				s1_v_q <= 1'b1;
			else if (adv)
				s1_v_q <= 1'b0;
			if (adv)
				rpt_valid_q <= 1'b1;
			else if (!rpt_stall)
				rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc && cmd.action == ACT_EVALUATE)
			now_q <= cmd.now_ms;
		if (can_issue)
			idx_s1 <= rd_idx_q;
		if (adv) begin
			rpt_q.report_module  <= idx_s1;
			rpt_q.hb_good        <= !lost;
			rpt_q.losses         <= new_loss;
			rpt_q.last_of_run    <= (idx_s1 == LAST_MOD);
			rpt_q.crit_any       <= (idx_s1 == LAST_MOD) && (crit_next != '0);
			rpt_q.critical_total <= (idx_s1 == LAST_MOD) ? crit_next : '0;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

endmodule

`default_nettype wire

// File: rtl/core/multi_channel_heartbeat_watchdog_unit.sv
// Top level of the multi-channel heartbeat watchdog.
// Depends on mchw_pkg, mchw_cfg, mchw_ram and mchw_ctrl.
//
//  channel | signals                      | carries
//  --------+------------------------------+------------------------------------
//  cmd     | cmd_valid, cmd_stall, cmd    | action, module index, time (ms)
//  rpt     | rpt_valid, rpt_stall, rpt    | one transaction per module on evaluate
//  cfg     | cfg_we, cfg_index, cfg_data  | timeouts and tolerances, write only
//
// Heartbeat and reset commands take effect on acceptance. An evaluate reads
// the state memory once per module, one module per cycle while the output
// does not stall, through the single registered read port.
// Output stalls hold the pipeline; cmd_stall stays high until the run drains.
// Reset clears heard flags and registers at once; no memory sweep is needed.
`default_nettype none

module multi_channel_heartbeat_watchdog_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_stall,
	input  wire mchw_pkg::cmd_t                 cmd,
	output logic                                rpt_valid,
	input  wire logic                           rpt_stall,
	output mchw_pkg::rpt_t                      rpt,
	input  wire logic                           cfg_we,
	input  wire logic [mchw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mchw_pkg::CFG_W-1:0]     cfg_data
);
	import mchw_pkg::*;

	cfg_t      cfg;
	ram_req_t  ram_req;
	ram_word_t ram_rdata;

	mchw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mchw_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	mchw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt       (rpt),
		.cfg       (cfg),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// File: rtl/core/mchw_chk.sv
// Port-level checker for the heartbeat watchdog, bound to the top level.
// Depends on mchw_pkg and the assertion macros header.
`default_nettype none
`include "multi_channel_heartbeat_watchdog_unit_defines.svh"

module mchw_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_stall,
	input wire mchw_pkg::cmd_t cmd,
	input wire logic           rpt_valid,
	input wire logic           rpt_stall,
	input wire mchw_pkg::rpt_t rpt
);
	import mchw_pkg::*;

	`MCHW_ASSERT_NEXT(a_rpt_hold, rpt_valid && rpt_stall, rpt_valid && $stable(rpt))
	`MCHW_ASSERT_NEXT(a_eval_busy, cmd_valid && !cmd_stall && cmd.action == ACT_EVALUATE, cmd_stall)
	`MCHW_ASSERT_NOW(a_mid, rpt_valid && !rpt.last_of_run, !rpt.crit_any && rpt.critical_total == '0)
	`MCHW_ASSERT_NOW(a_ok_no_loss, rpt_valid && rpt.hb_good, rpt.losses == '0)
	`MCHW_ASSERT_NOW(a_flag, rpt_valid && rpt.last_of_run, rpt.crit_any == (rpt.critical_total != '0))

endmodule

bind multi_channel_heartbeat_watchdog_unit mchw_chk u_mchw_chk (.*);

`default_nettype wire

// File: dv/multi_channel_heartbeat_watchdog_unit_test.sv
// Self-checking testbench for multi_channel_heartbeat_watchdog_unit.
// Depends on mchw_pkg; directed table, then randomized heartbeats/evaluates
// with random cmd gaps and rpt stalls, checked against an in-bench predictor.
`default_nettype none

module multi_channel_heartbeat_watchdog_unit_test;
	import mchw_pkg::*;

	localparam int SETTLE_CYCLES = NUM_MODULES + 4;
	localparam int HOLD_CYCLES   = 60;

	typedef struct packed {
		cmd_t        cmd;
		logic        typed;
		logic [7:0]  ok_mask;
		logic [7:0]  lost_losses;
		logic [3:0]  total;
	} stim_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_t                 cmd = '0;
	logic                 rpt_valid;
	logic                 rpt_stall = 1'b0;
	rpt_t                 rpt;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	multi_channel_heartbeat_watchdog_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt       (rpt),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted watchdog state
	cfg_t        cfg_shadow;
	logic [31:0] seen_ms  [NUM_MODULES];
	logic [7:0]  miss_cnt [NUM_MODULES];
	bit          heard    [NUM_MODULES];

	stim_t send_q [$];
	rpt_t  rpt_expect_q [$];
	stim_t cur_cmd;
	int    cmds_pending = 0;
	int    mismatch_cnt = 0;
	int    tx_idle_pct  = 0;
	int    rx_idle_pct  = 0;
	bit    hold_req     = 1'b0;
	logic [31:0] clock_ms = '0;

	// typed rows: ok_mask bit per module, losses of lost modules, critical total
	stim_t directed_tbl [23] = '{
		'{'{ACT_EVALUATE,  3'd0, 32'd0},          1'b1, 8'hFF, 8'd0, 4'd0},
		'{'{ACT_HEARTBEAT, 3'd0, 32'd0},          1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_HEARTBEAT, 3'd7, 32'd100},        1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'd100},        1'b1, 8'hFF, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'd101},        1'b1, 8'h7F, 8'd1, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'd1500},       1'b1, 8'h7F, 8'd2, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'd1501},       1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'd1502},       1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_RESET_ONE, 3'd7, 32'hFFFF_FFFF},  1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'd1503},       1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_HEARTBEAT, 3'd2, 32'hFFFF_FFFF},  1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_HEARTBEAT, 3'd3, 32'hFFFF_FF00},  1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'h0000_0100},  1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'hFFFF_FFFF},  1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_RESET_ALL, 3'd0, 32'd0},          1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'hFFFF_FFFF},  1'b1, 8'hFF, 8'd0, 4'd0},
		'{'{ACT_HEARTBEAT, 3'd1, 32'd0},          1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_HEARTBEAT, 3'd4, 32'd0},          1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_HEARTBEAT, 3'd5, 32'd0},          1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_HEARTBEAT, 3'd6, 32'd0},          1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'hFFFF_FFFF},  1'b1, 8'h8D, 8'd1, 4'd0},
		'{'{ACT_RESET_ONE, 3'd5, 32'd0},          1'b0, 8'h00, 8'd0, 4'd0},
		'{'{ACT_EVALUATE,  3'd0, 32'hFFFF_FFFF},  1'b0, 8'h00, 8'd0, 4'd0}
	};

	function automatic void clear_module(input int m);
		seen_ms[m]  = '0;
		miss_cnt[m] = '0;
		heard[m]    = 1'b0;
	endfunction

	// updates the predicted state and queues the reports this command causes
	function automatic void watchdog_step(input stim_t s);
		rpt_t        r;
		logic [15:0] tmo;
		logic [31:0] elapsed;
		int          crit;
		int          idx;
		crit = 0;
		idx  = int'(s.cmd.module_index);
		case (s.cmd.action)
			ACT_HEARTBEAT: begin
				seen_ms[idx]  = s.cmd.now_ms;
				miss_cnt[idx] = '0;
				heard[idx]    = 1'b1;
			end
			ACT_RESET_ONE: clear_module(idx);
			ACT_RESET_ALL: for (int m = 0; m < NUM_MODULES; m++) clear_module(m);
			ACT_EVALUATE: begin
				for (int m = 0; m < NUM_MODULES; m++) begin
					r = '0;
					r.report_module = 3'(m);
					r.hb_good       = 1'b1;
					if (heard[m]) begin
						elapsed = s.cmd.now_ms - seen_ms[m];
						tmo = (m < 4) ? cfg_shadow.timeouts_low[16*m +: 16]
						              : cfg_shadow.timeouts_high[16*(m-4) +: 16];
						if (elapsed > 32'(tmo)) begin
							if (miss_cnt[m] != 8'hFF)
								miss_cnt[m] = miss_cnt[m] + 8'd1;
							r.hb_good = 1'b0;
							r.losses  = miss_cnt[m];
						end else begin
							miss_cnt[m] = '0;
						end
						if (miss_cnt[m] > cfg_shadow.tolerances[8*m +: 8])
							crit++;
					end
					if (m == NUM_MODULES - 1) begin
						r.last_of_run    = 1'b1;
						r.crit_any       = (crit != 0);
						r.critical_total = 4'(crit);
					end
					if (s.typed) begin
						r.hb_good = s.ok_mask[m];
						r.losses  = s.ok_mask[m] ? 8'd0 : s.lost_losses;
						if (m == NUM_MODULES - 1) begin
							r.crit_any       = (s.total != 0);
							r.critical_total = s.total;
						end
					end
					rpt_expect_q.push_back(r);
				end
			end
		endcase
	endfunction

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("mismatch %s: expected %0h, got %0h", what, want, got);
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	// command sender and predictor hook
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				watchdog_step(cur_cmd);
				cmds_pending--;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (send_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					cur_cmd = send_q.pop_front();
					cmd       <= cur_cmd.cmd;
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// report checker
	always @(posedge clk) begin
		rpt_t want;
		if (arst_n && rpt_valid && !rpt_stall) begin
			if (rpt_expect_q.size() == 0) begin
				flag_mismatch("unexpected transaction, module", 'x, 32'(rpt.report_module));
			end else begin
				want = rpt_expect_q.pop_front();
				if (rpt.report_module !== want.report_module)
					flag_mismatch("report_module", 32'(want.report_module),
						32'(rpt.report_module));
				if (rpt.hb_good !== want.hb_good)
					flag_mismatch("hb_good", 32'(want.hb_good), 32'(rpt.hb_good));
				if (rpt.losses !== want.losses)
					flag_mismatch("losses", 32'(want.losses), 32'(rpt.losses));
				if (rpt.last_of_run !== want.last_of_run)
					flag_mismatch("last_of_run", 32'(want.last_of_run), 32'(rpt.last_of_run));
				if (rpt.crit_any !== want.crit_any)
					flag_mismatch("crit_any", 32'(want.crit_any), 32'(rpt.crit_any));
				if (rpt.critical_total !== want.critical_total)
					flag_mismatch("critical_total", 32'(want.critical_total),
						32'(rpt.critical_total));
			end
		end
	end

	// receiver stall; a toggle of hold_req starts one long hold
	initial begin : rx_stall_drv
		bit seen_req;
		int hold_left;
		seen_req  = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != seen_req) begin
				seen_req  = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rpt_stall <= 1'b1;
			end else begin
				rpt_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	task automatic queue_cmd(input stim_t s);
		send_q.push_back(s);
		cmds_pending++;
	endtask

	task automatic queue_op(input action_t act, input logic [2:0] idx,
			input logic [31:0] now);
		stim_t s;
		s = '0;
		s.cmd.action       = act;
		s.cmd.module_index = idx;
		s.cmd.now_ms       = now;
		queue_cmd(s);
	endtask

	task automatic drain;
		while (cmds_pending != 0 || rpt_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIMEOUTS_LOW:  cfg_shadow.timeouts_low  = data;
			REG_TIMEOUTS_HIGH: cfg_shadow.timeouts_high = data;
			REG_TOLERANCES:    cfg_shadow.tolerances    = data;
			default: ;
		endcase
	endtask

	task automatic write_moderate_cfg;
		logic [CFG_W-1:0] lo, hi, tol;
		for (int i = 0; i < 4; i++) begin
			lo[16*i +: 16] = 16'($urandom_range(0, 2000));
			hi[16*i +: 16] = 16'($urandom_range(0, 2000));
		end
		for (int i = 0; i < 8; i++)
			tol[8*i +: 8] = 8'($urandom_range(0, 4));
		write_reg(REG_TIMEOUTS_LOW, lo);
		write_reg(REG_TIMEOUTS_HIGH, hi);
		write_reg(REG_TOLERANCES, tol);
	endtask

	// mostly well-formed traffic on an advancing ms clock, some raw noise
	task automatic queue_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			clock_ms = clock_ms + 32'($urandom_range(0, 700));
			r = $urandom_range(99);
			if (r < 38)
				queue_op(ACT_HEARTBEAT, 3'($urandom_range(7)), clock_ms);
			else if (r < 80)
				queue_op(ACT_EVALUATE, 3'($urandom_range(7)), clock_ms);
			else if (r < 88)
				queue_op(ACT_RESET_ONE, 3'($urandom_range(7)), clock_ms);
			else if (r < 91)
				queue_op(ACT_RESET_ALL, 3'($urandom_range(7)), clock_ms);
			else
				queue_op(action_t'($urandom_range(3)), 3'($urandom_range(7)), $urandom());
		end
	endtask

	initial begin
		cfg_shadow.timeouts_low  = TIMEOUTS_LOW_RST;
		cfg_shadow.timeouts_high = TIMEOUTS_HIGH_RST;
		cfg_shadow.tolerances    = TOLERANCES_RST;
		for (int m = 0; m < NUM_MODULES; m++) clear_module(m);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 22;
		rx_idle_pct = 80;
		foreach (directed_tbl[i]) queue_cmd(directed_tbl[i]);
		drain();

		// zero timeouts and tolerances; unused index must be ignored
		write_reg(REG_TIMEOUTS_LOW, '0);
		write_reg(REG_TIMEOUTS_HIGH, '0);
		write_reg(REG_TOLERANCES, '0);
		write_reg(REG_UNUSED, {$urandom(), $urandom()});
		queue_random(30);
		drain();

		tx_idle_pct = 80;
		rx_idle_pct = 22;
		write_moderate_cfg();
		queue_random(30);
		drain();

		// all-ones settings; long receiver hold with back-to-back evaluates
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_reg(REG_TIMEOUTS_LOW, '1);
		write_reg(REG_TIMEOUTS_HIGH, '1);
		write_reg(REG_TOLERANCES, '1);
		write_reg(REG_UNUSED, '0);
		hold_req = ~hold_req;
		for (int i = 0; i < 3; i++) begin
			clock_ms = clock_ms + 32'd40000;
			queue_op(ACT_HEARTBEAT, 3'(i), clock_ms);
			queue_op(ACT_EVALUATE, 3'd0, clock_ms + 32'd70000);
			queue_op(ACT_EVALUATE, 3'd0, clock_ms + 32'd65535);
		end
		drain();

		write_moderate_cfg();
		queue_random(30);
		drain();

		if (mismatch_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(20 * 200_000);
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/mchw_pkg.sv
rtl/core/mchw_cfg.sv
rtl/core/mchw_ram.sv
rtl/core/mchw_ctrl.sv
rtl/core/multi_channel_heartbeat_watchdog_unit.sv
rtl/core/mchw_chk.sv
dv/multi_channel_heartbeat_watchdog_unit_test.sv
